[rtl/core/gic_pkg.sv]
// gic_pkg: shared widths, register indexes and control types of the
// gamepad input conditioner; no dependencies
package gic_pkg;

  localparam int SAMPLE_W   = 12;
  localparam int TIME_W     = 48;
  localparam int SHIFT_W    = 4;
  localparam int DZ_W       = 7;
  localparam int DEB_W      = 20;
  localparam int LONG_W     = 24;
  localparam int CFG_W      = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int AXES       = 4;
  localparam int CHANNELS   = 5;
  localparam int MAX_BTN    = 8;
  localparam int AXIS_OUT_W = 8;

  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {SAMPLE_W{1'b1}};
  localparam int PCT_FULL  = 100;
  localparam int MV_FULL   = 3300;

  // axis divider: dividend is diff*100 + span/2, quotient never above 100
  localparam int AX_NUM_W  = SAMPLE_W + 7;
  localparam int AX_Q_W    = 7;
  // battery scaling: raw*3300 divided by full scale 2^12-1 as
  // (x + (x >> 12) + 1) >> 12, exact for quotients below 4096
  localparam int BAT_NUM_W = SAMPLE_W + 12;
  localparam int BAT_Q_W   = SAMPLE_W;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FILTER_SHIFT   = 3'd0,
    REG_DEAD_ZONE      = 3'd1,
    REG_CENTER_LX      = 3'd2,
    REG_CENTER_LY      = 3'd3,
    REG_CENTER_RX      = 3'd4,
    REG_CENTER_RY      = 3'd5,
    REG_DEBOUNCE_TIME  = 3'd6,
    REG_LONG_TIME      = 3'd7
  } cfg_reg_t;

  // per-button flags reported by a debounce lane
  typedef struct packed {
    logic pressed;
    logic press_edge;
    logic release_edge;
    logic long_press;
  } btn_flags_t;

endpackage

[rtl/core/gic_filter.sv]
// gic_filter: one exponential filter lane for a converter sample
// depends on gic_pkg
module gic_filter (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          load,
  input  logic [gic_pkg::SHIFT_W-1:0]   shift,
  input  logic [gic_pkg::SAMPLE_W-1:0]  sample,
  output logic [gic_pkg::SAMPLE_W-1:0]  value
);
  import gic_pkg::*;

  localparam int WW = SAMPLE_W + (1 << SHIFT_W) + 2;

  logic [SAMPLE_W-1:0]  value_r, value_nxt;
  logic signed [WW-1:0] diff, bias, stepped;

  // step toward the sample, truncated toward zero
  always_comb begin
    diff    = $signed({{(WW-SAMPLE_W){1'b0}}, sample}) -
              $signed({{(WW-SAMPLE_W){1'b0}}, value_r});
    bias    = diff[WW-1] ? $signed((({{(WW-1){1'b0}}, 1'b1}) << shift) -
              {{(WW-1){1'b0}}, 1'b1}) : '0;
    stepped = (diff + bias) >>> shift;
    if (value_r == '0) begin
      value_nxt = sample;
    end else begin
      value_nxt = value_r + stepped[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      value_r <= '0;
    end else if (load) begin
      value_r <= value_nxt;
    end
  end

  assign value = value_r;

endmodule

[rtl/core/gic_btn.sv]
// gic_btn: one button debounce lane with edge and long-press detection
// depends on gic_pkg
module gic_btn (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        load,
  input  logic [gic_pkg::TIME_W-1:0]  now_us,
  input  logic                        level,
  input  logic [gic_pkg::DEB_W-1:0]   debounce_time,
  input  logic [gic_pkg::LONG_W-1:0]  long_press_time,
  output gic_pkg::btn_flags_t         flags
);
  import gic_pkg::*;

  logic              sampled_r, sampled_nxt;
  logic              stable_r, stable_nxt;
  logic [TIME_W-1:0] change_r, change_nxt;
  logic [TIME_W-1:0] start_r, start_nxt;
  btn_flags_t        flags_r, flags_nxt;
  logic [TIME_W-1:0] since_change, since_press;
  logic              settled;

  // debounce by elapsed time, then edge and hold checks
  always_comb begin
    sampled_nxt  = sampled_r;
    change_nxt   = change_r;
    stable_nxt   = stable_r;
    start_nxt    = start_r;
    flags_nxt    = '0;
    since_change = now_us - change_r;
    if (level != sampled_r) begin
      sampled_nxt  = level;
      change_nxt   = now_us;
      since_change = '0;
    end
    settled = since_change >= {{(TIME_W-DEB_W){1'b0}}, debounce_time};
    if (stable_r != sampled_nxt && settled) begin
      stable_nxt = sampled_nxt;
      if (!sampled_nxt) begin
        flags_nxt.press_edge = 1'b1;
        start_nxt = now_us;
      end else begin
        flags_nxt.release_edge = 1'b1;
        start_nxt = '0;
      end
    end
    since_press = now_us - start_nxt;
    if (!stable_nxt) begin
      flags_nxt.pressed    = 1'b1;
      flags_nxt.long_press = since_press >= {{(TIME_W-LONG_W){1'b0}}, long_press_time};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sampled_r <= 1'b1;
      stable_r  <= 1'b1;
      change_r  <= '0;
      start_r   <= '0;
      flags_r   <= '0;
    end else if (load) begin
      sampled_r <= sampled_nxt;
      stable_r  <= stable_nxt;
      change_r  <= change_nxt;
      start_r   <= start_nxt;
      flags_r   <= flags_nxt;
    end
  end

  assign flags = flags_r;

endmodule

[rtl/core/gic_div.sv]
// gic_div: restoring divider, one quotient bit per cycle
// depends on nothing; quotient must fit in Q_W bits
module gic_div #(
  parameter int NUM_W = 19,
  parameter int DEN_W = 12,
  parameter int Q_W   = 7
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [Q_W-1:0]   quot
);

  localparam int CNT_W = $clog2(Q_W + 1);

  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r;
  logic [Q_W-1:0]   shf_r, shf_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic             done_r;
  logic [DEN_W:0]   trial;
  logic             fits;

  // one compare and subtract per cycle
  always_comb begin
    trial   = {rem_r, shf_r[Q_W-1]};
    fits    = trial >= {1'b0, den_r};
    rem_nxt = fits ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
    shf_nxt = {shf_r[Q_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (start) begin
      cnt_r  <= CNT_W'(Q_W);
      done_r <= 1'b0;
    end else if (cnt_r != '0) begin
      cnt_r  <= cnt_r - 1'b1;
      done_r <= (cnt_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num[NUM_W-1:Q_W];
      shf_r <= num[Q_W-1:0];
      den_r <= den;
    end else if (cnt_r != '0) begin
      rem_r <= rem_nxt;
      shf_r <= shf_nxt;
    end
  end

  assign done = done_r;
  assign quot = shf_r;

endmodule

[rtl/core/gic_axis.sv]
// gic_axis: one stick axis lane, scales around center with rounding,
// clamps and applies the dead zone; depends on gic_pkg and gic_div
module gic_axis (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [gic_pkg::SAMPLE_W-1:0]    raw,
  input  logic [gic_pkg::SAMPLE_W-1:0]    center,
  input  logic [gic_pkg::DZ_W-1:0]        dead_zone,
  output logic                            done,
  output logic signed [gic_pkg::AXIS_OUT_W-1:0] value
);
  import gic_pkg::*;

  logic                neg_r;
  logic                upper;
  logic [SAMPLE_W-1:0] span, delta;
  logic [AX_NUM_W-1:0] num;
  logic [AX_Q_W-1:0]   quot, mag;

  // span and rounded dividend for the side of center the sample is on
  always_comb begin
    upper = raw >= center;
    if (upper) begin
      span  = (center < SAMPLE_MAX) ? SAMPLE_MAX - center : SAMPLE_W'(1);
      delta = raw - center;
    end else begin
      span  = (center != '0) ? center : SAMPLE_W'(1);
      delta = center - raw;
    end
    num = AX_NUM_W'(delta) * AX_NUM_W'(PCT_FULL) + AX_NUM_W'(span >> 1);
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= !upper;
    end
  end

  gic_div #(
    .NUM_W (AX_NUM_W),
    .DEN_W (SAMPLE_W),
    .Q_W   (AX_Q_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .num   (num),
    .den   (span),
    .done  (done),
    .quot  (quot)
  );

  // clamp and dead zone
  always_comb begin
    mag = (quot > AX_Q_W'(PCT_FULL)) ? AX_Q_W'(PCT_FULL) : quot;
    if (mag <= dead_zone) begin
      value = '0;
    end else if (neg_r) begin
      value = -$signed({1'b0, mag});
    end else begin
      value = $signed({1'b0, mag});
    end
  end

endmodule

[rtl/core/gamepad_input_conditioner_unit.sv]
// gamepad_input_conditioner_unit: top level, button and filter lanes,
// axis and battery scaling lanes, merge into one result transaction
// depends on gic_pkg, gic_filter, gic_btn, gic_axis, gic_div
//
//  channel | signals                          | transaction
//  in      | in_valid / in_ready, 7 fields    | one poll tick
//  out     | out_valid / out_ready, 11 fields | one conditioned tick
//  cfg     | cfg_we, cfg_index, cfg_wdata     | one register write
//
// Filters and debounce lanes update at the accepting edge; ST_START then loads
// the axis dividers, ST_DIV waits for all quotient bits, and ST_MERGE raises
// out_valid. Battery millivolts come from a reciprocal multiply. in_ready is low
// from acceptance to the merge, so no tick is taken before the last is merged.
// Reset is synchronous and active low and sets all buttons released and filters
// empty; the merge holds while a finished result waits for out_ready.
module gamepad_input_conditioner_unit #(
  parameter int BUTTONS = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [gic_pkg::TIME_W-1:0]         in_now_us,
  input  logic [gic_pkg::MAX_BTN-1:0]        in_button_levels,
  input  logic [gic_pkg::SAMPLE_W-1:0]       in_sample_left_x,
  input  logic [gic_pkg::SAMPLE_W-1:0]       in_sample_left_y,
  input  logic [gic_pkg::SAMPLE_W-1:0]       in_sample_right_x,
  input  logic [gic_pkg::SAMPLE_W-1:0]       in_sample_right_y,
  input  logic [gic_pkg::SAMPLE_W-1:0]       in_sample_battery,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [gic_pkg::AXIS_OUT_W-1:0] out_left_x,
  output logic signed [gic_pkg::AXIS_OUT_W-1:0] out_left_y,
  output logic signed [gic_pkg::AXIS_OUT_W-1:0] out_right_x,
  output logic signed [gic_pkg::AXIS_OUT_W-1:0] out_right_y,
  output logic [3:0]                         out_front_buttons,
  output logic [3:0]                         out_trigger_buttons,
  output logic [gic_pkg::MAX_BTN-1:0]        out_press_edges,
  output logic [gic_pkg::MAX_BTN-1:0]        out_release_edges,
  output logic [gic_pkg::MAX_BTN-1:0]        out_long_press_flags,
  output logic [gic_pkg::SAMPLE_W-1:0]       out_battery_raw,
  output logic [gic_pkg::SAMPLE_W-1:0]       out_battery_millivolts,
  input  logic                               cfg_we,
  input  logic [gic_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gic_pkg::CFG_W-1:0]          cfg_wdata
);
  import gic_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_START = 4'b0010,
    ST_DIV   = 4'b0100,
    ST_MERGE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [SHIFT_W-1:0]  filter_shift_r;
  logic [DZ_W-1:0]     dead_zone_r;
  logic [SAMPLE_W-1:0] center_r [AXES];
  logic [DEB_W-1:0]    debounce_r;
  logic [LONG_W-1:0]   long_time_r;

  logic                accept;
  logic                start;
  logic                merge;
  logic [SAMPLE_W-1:0] samples  [CHANNELS];
  logic [SAMPLE_W-1:0] filtered [CHANNELS];
  btn_flags_t          btn      [MAX_BTN];
  logic [AXES-1:0]     ax_done;
  logic signed [AXIS_OUT_W-1:0] ax_val [AXES];
  logic [BAT_Q_W-1:0]  bat_mv;
  logic [BAT_NUM_W-1:0] bat_num;
  logic [BAT_NUM_W-1:0] bat_sum;
  logic [MAX_BTN-1:0]  pressed, press_e, release_e, long_f;

  logic                out_valid_r;
  logic signed [AXIS_OUT_W-1:0] out_axis_r [AXES];
  logic [MAX_BTN-1:0]  out_pressed_r, out_press_r, out_release_r, out_long_r;
  logic [SAMPLE_W-1:0] out_bat_raw_r, out_bat_mv_r;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE);
  assign start    = (state_r == ST_START);
  assign merge    = (state_r == ST_MERGE) && (!out_valid_r || out_ready);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_shift_r <= SHIFT_W'(2);
      dead_zone_r    <= DZ_W'(5);
      for (int i = 0; i < AXES; i++) begin
        center_r[i] <= SAMPLE_W'(2048);
      end
      debounce_r     <= DEB_W'(40000);
      long_time_r    <= LONG_W'(800000);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FILTER_SHIFT:  filter_shift_r <= cfg_wdata[SHIFT_W-1:0];
        REG_DEAD_ZONE:     dead_zone_r    <= cfg_wdata[DZ_W-1:0];
        REG_CENTER_LX:     center_r[0]    <= cfg_wdata[SAMPLE_W-1:0];
        REG_CENTER_LY:     center_r[1]    <= cfg_wdata[SAMPLE_W-1:0];
        REG_CENTER_RX:     center_r[2]    <= cfg_wdata[SAMPLE_W-1:0];
        REG_CENTER_RY:     center_r[3]    <= cfg_wdata[SAMPLE_W-1:0];
        REG_DEBOUNCE_TIME: debounce_r     <= cfg_wdata[DEB_W-1:0];
        REG_LONG_TIME:     long_time_r    <= cfg_wdata[LONG_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (accept) state_nxt = ST_START;
      ST_START: state_nxt = ST_DIV;
      ST_DIV:   if (&ax_done) state_nxt = ST_MERGE;
      ST_MERGE: if (merge) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // filter lanes
  assign samples[0] = in_sample_left_x;
  assign samples[1] = in_sample_left_y;
  assign samples[2] = in_sample_right_x;
  assign samples[3] = in_sample_right_y;
  assign samples[4] = in_sample_battery;

  for (genvar c = 0; c < CHANNELS; c++) begin : g_filt
    gic_filter u_filt (
      .clk    (clk),
      .rst_n  (rst_n),
      .load   (accept),
      .shift  (filter_shift_r),
      .sample (samples[c]),
      .value  (filtered[c])
    );
  end

  // debounce lanes, unused buttons report nothing
  for (genvar b = 0; b < MAX_BTN; b++) begin : g_btn
    if (b < BUTTONS) begin : g_used
      gic_btn u_btn (
        .clk             (clk),
        .rst_n           (rst_n),
        .load            (accept),
        .now_us          (in_now_us),
        .level           (in_button_levels[b]),
        .debounce_time   (debounce_r),
        .long_press_time (long_time_r),
        .flags           (btn[b])
      );
    end else begin : g_unused
      assign btn[b] = '0;
    end
    assign pressed[b]   = btn[b].pressed;
    assign press_e[b]   = btn[b].press_edge;
    assign release_e[b] = btn[b].release_edge;
    assign long_f[b]    = btn[b].long_press;
  end

  // axis lanes
  for (genvar a = 0; a < AXES; a++) begin : g_axis
    gic_axis u_axis (
      .clk       (clk),
      .rst_n     (rst_n),
      .start     (start),
      .raw       (filtered[a]),
      .center    (center_r[a]),
      .dead_zone (dead_zone_r),
      .done      (ax_done[a]),
      .value     (ax_val[a])
    );
  end

  // battery lane: raw * 3300 / 4095 by folding the high part back in
  assign bat_num = BAT_NUM_W'(filtered[4]) * BAT_NUM_W'(MV_FULL);
  assign bat_sum = bat_num + (bat_num >> SAMPLE_W) + BAT_NUM_W'(1);
  assign bat_mv  = bat_sum[BAT_NUM_W-1:SAMPLE_W];

  // merge lanes into the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (merge) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (merge) begin
      for (int i = 0; i < AXES; i++) begin
        out_axis_r[i] <= ax_val[i];
      end
      out_pressed_r <= pressed;
      out_press_r   <= press_e;
      out_release_r <= release_e;
      out_long_r    <= long_f;
      out_bat_raw_r <= filtered[4];
      out_bat_mv_r  <= bat_mv;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_left_x             = out_axis_r[0];
  assign out_left_y             = out_axis_r[1];
  assign out_right_x            = out_axis_r[2];
  assign out_right_y            = out_axis_r[3];
  assign out_front_buttons      = out_pressed_r[3:0];
  assign out_trigger_buttons    = out_pressed_r[7:4];
  assign out_press_edges        = out_press_r;
  assign out_release_edges      = out_release_r;
  assign out_long_press_flags   = out_long_r;
  assign out_battery_raw        = out_bat_raw_r;
  assign out_battery_millivolts = out_bat_mv_r;

endmodule

[bench/tb_gamepad_input_conditioner_unit.sv]
// tb_gamepad_input_conditioner_unit: self-checking bench for the gamepad input conditioner
// depends on gic_pkg and gamepad_input_conditioner_unit; drives ticks, predicts and checks
module tb_gamepad_input_conditioner_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import gic_pkg::*;

  localparam logic [TIME_W-1:0] TIME_MASK = {TIME_W{1'b1}};
  localparam int IDLE_LIMIT = 2000;

  typedef struct packed {
    logic signed [7:0] left_x, left_y, right_x, right_y;
    logic [3:0] front, trigger;
    logic [7:0] press_edges, release_edges, long_flags;
    logic [11:0] bat_raw, bat_mv;
  } tick_result_t;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [TIME_W-1:0] in_now_us;
  logic [7:0] in_button_levels;
  logic [11:0] in_sample_left_x, in_sample_left_y, in_sample_right_x;
  logic [11:0] in_sample_right_y, in_sample_battery;
  logic signed [7:0] out_left_x, out_left_y, out_right_x, out_right_y;
  logic [3:0] out_front_buttons, out_trigger_buttons;
  logic [7:0] out_press_edges, out_release_edges, out_long_press_flags;
  logic [11:0] out_battery_raw, out_battery_millivolts;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  gamepad_input_conditioner_unit DUT (.*);

  // predictor state
  logic [3:0] p_shift;
  logic [6:0] p_dead_zone;
  logic [11:0] p_center [AXES];
  logic [19:0] p_debounce;
  logic [23:0] p_long;
  logic [7:0] p_sampled, p_stable;
  logic [TIME_W-1:0] p_change_t [8];
  logic [TIME_W-1:0] p_press_t [8];
  logic [11:0] p_filtered [CHANNELS];

  tick_result_t expected_ticks[$];
  int errors = 0;
  int ticks_sent = 0;
  int ticks_checked = 0;
  int idle_cycles = 0;
  bit idling_on = 1;
  logic [TIME_W-1:0] clock_us = '0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic logic signed [7:0] scale_axis(logic [11:0] raw, logic [11:0] center);
    int span, v;
    if (raw >= center) begin
      span = (center < SAMPLE_MAX) ? int'(SAMPLE_MAX) - center : 1;
      v = ((raw - center) * 100 + span / 2) / span;
    end else begin
      span = (center > 0) ? center : 1;
      v = -(((center - raw) * 100 + span / 2) / span);
    end
    if (v > 100) v = 100;
    if (v < -100) v = -100;
    if (v >= -int'(p_dead_zone) && v <= int'(p_dead_zone)) v = 0;
    return v[7:0];
  endfunction

  function automatic void predict_tick(logic [TIME_W-1:0] now, logic [7:0] levels,
                                       logic [11:0] smp [CHANNELS]);
    tick_result_t r;
    int diff, stp;
    logic [7:0] pressed;
    r = '0;
    pressed = '0;
    // exponential filters, truncating toward zero
    for (int i = 0; i < CHANNELS; i++) begin
      if (p_filtered[i] == 0) p_filtered[i] = smp[i];
      else begin
        diff = int'(smp[i]) - int'(p_filtered[i]);
        stp = diff / (1 << p_shift);
        p_filtered[i] = 12'(int'(p_filtered[i]) + stp);
      end
    end
    // debounce lanes
    for (int i = 0; i < 8; i++) begin
      if (levels[i] != p_sampled[i]) begin
        p_sampled[i] = levels[i];
        p_change_t[i] = now;
      end
      if (p_stable[i] != p_sampled[i] &&
          ((now - p_change_t[i]) & TIME_MASK) >= TIME_W'(p_debounce)) begin
        p_stable[i] = p_sampled[i];
        if (!p_stable[i]) begin
          r.press_edges[i] = 1;
          p_press_t[i] = now;
        end else begin
          r.release_edges[i] = 1;
          p_press_t[i] = '0;
        end
      end
      if (!p_stable[i]) begin
        pressed[i] = 1;
        if (((now - p_press_t[i]) & TIME_MASK) >= TIME_W'(p_long)) r.long_flags[i] = 1;
      end
    end
    r.left_x = scale_axis(p_filtered[0], p_center[0]);
    r.left_y = scale_axis(p_filtered[1], p_center[1]);
    r.right_x = scale_axis(p_filtered[2], p_center[2]);
    r.right_y = scale_axis(p_filtered[3], p_center[3]);
    r.front = pressed[3:0];
    r.trigger = pressed[7:4];
    r.bat_raw = p_filtered[4];
    r.bat_mv = 12'((p_filtered[4] * 3300) / 4095);
    expected_ticks.push_back(r);
  endfunction

  // optional gap before the next transaction, valid drops only when idling
  task automatic idle_burst();
    if (idling_on && $urandom_range(3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(7, 1)) @(posedge clk);
    end
  endtask

  // one tick transaction on the input channel
  task automatic send_tick(logic [TIME_W-1:0] now, logic [7:0] levels,
                           logic [11:0] lx, logic [11:0] ly, logic [11:0] rx,
                           logic [11:0] ry, logic [11:0] bat);
    logic [11:0] smp [CHANNELS];
    smp = '{lx, ly, rx, ry, bat};
    idle_burst();
    in_valid <= 1;
    in_now_us <= now;
    in_button_levels <= levels;
    in_sample_left_x <= lx;
    in_sample_left_y <= ly;
    in_sample_right_x <= rx;
    in_sample_right_y <= ry;
    in_sample_battery <= bat;
    do @(posedge clk); while (!in_ready);
    predict_tick(now, levels, smp);
    ticks_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 0;
    while (expected_ticks.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, int unsigned val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= CFG_W'(val);
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
    case (idx)
      REG_FILTER_SHIFT: p_shift = val[3:0];
      REG_DEAD_ZONE: p_dead_zone = val[6:0];
      REG_CENTER_LX: p_center[0] = val[11:0];
      REG_CENTER_LY: p_center[1] = val[11:0];
      REG_CENTER_RX: p_center[2] = val[11:0];
      REG_CENTER_RY: p_center[3] = val[11:0];
      REG_DEBOUNCE_TIME: p_debounce = val[19:0];
      REG_LONG_TIME: p_long = val[23:0];
      default: ;
    endcase
  endtask

  function automatic logic [11:0] rand_sample();
    case ($urandom_range(5))
      0: return 12'd0;
      1: return 12'hfff;
      2: return 12'(2048 + $urandom_range(200) - 100);
      default: return 12'($urandom);
    endcase
  endfunction

  // time step: usually a few ms, sometimes long or backward
  function automatic logic [TIME_W-1:0] next_time();
    case ($urandom_range(19))
      0: clock_us = clock_us - $urandom_range(100000);
      1: clock_us = clock_us + 48'($urandom_range(2000000));
      2: clock_us = TIME_W'({$urandom, $urandom});
      default: clock_us = clock_us + $urandom_range(20000);
    endcase
    return clock_us;
  endfunction

  // result checker
  always @(posedge clk) begin
    tick_result_t act, exp_r;
    if (rst_n && out_valid && out_ready) begin
      act = '{out_left_x, out_left_y, out_right_x, out_right_y, out_front_buttons,
              out_trigger_buttons, out_press_edges, out_release_edges,
              out_long_press_flags, out_battery_raw, out_battery_millivolts};
      if (expected_ticks.size() == 0) begin
        $display("%0t unexpected result %p", $time, act);
        errors++;
      end else begin
        exp_r = expected_ticks.pop_front();
        ticks_checked++;
        if (act !== exp_r) begin
          $display("%0t mismatch expected %p actual %p", $time, exp_r, act);
          errors++;
        end
      end
    end
  end

  // result side stall
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1;
    else if (idling_on && $urandom_range(7) == 0) out_ready <= 0;
    else if (!out_ready && $urandom_range(2) != 0) out_ready <= 0;
    else out_ready <= 1;
  end

  // watchdog on transactions
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we || !in_valid &&
        expected_ticks.size() == 0) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t watchdog expired", $time);
      $display("tb_gamepad_input_conditioner_unit: FAIL");
      $finish;
    end
  end

  task automatic test_reset_defaults();
    send_tick(0, 8'hff, 12'd2048, 12'd0, 12'hfff, 12'd1, 12'hfff);
    send_tick(100, 8'h00, 12'd0, 12'hfff, 12'd0, 12'd2100, 12'd0);
    send_tick(40100, 8'h00, 12'hfff, 12'd0, 12'd2048, 12'd4000, 12'd1);
    send_tick(900100, 8'h00, 12'd1234, 12'd3000, 12'd1, 12'd2, 12'd3000);
    send_tick(950100, 8'hff, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0);
    send_tick(999999, 8'hff, 12'd7, 12'd7, 12'd7, 12'd7, 12'd7);
    wait_drained();
  endtask

  task automatic test_config_extremes();
    write_reg(REG_FILTER_SHIFT, 0);
    write_reg(REG_DEAD_ZONE, 0);
    write_reg(REG_CENTER_LX, 0);
    write_reg(REG_CENTER_LY, 4095);
    write_reg(REG_CENTER_RX, 1);
    write_reg(REG_CENTER_RY, 4094);
    write_reg(REG_DEBOUNCE_TIME, 0);
    write_reg(REG_LONG_TIME, 0);
    send_tick(48'hffff_ffff_fff0, 8'h5a, 12'd0, 12'hfff, 12'd0, 12'hfff, 12'hfff);
    send_tick(48'h10, 8'ha5, 12'hfff, 12'd0, 12'd1, 12'd4094, 12'd1);
    send_tick(48'h5, 8'hff, 12'd2048, 12'd2047, 12'd1, 12'd4095, 12'd2048);
    wait_drained();
    write_reg(REG_FILTER_SHIFT, 15);
    write_reg(REG_DEAD_ZONE, 127);
    write_reg(REG_DEBOUNCE_TIME, 1048575);
    write_reg(REG_LONG_TIME, 16777215);
    send_tick(48'h20, 8'h00, 12'hfff, 12'd0, 12'hfff, 12'd0, 12'd0);
    send_tick(48'h0010_0020, 8'h00, 12'd0, 12'hfff, 12'd0, 12'hfff, 12'hfff);
    send_tick(48'h0210_0020, 8'h00, 12'd1, 12'd1, 12'd1, 12'd1, 12'd1);
    wait_drained();
    write_reg(REG_DEAD_ZONE, 100);
    send_tick(48'h0310_0020, 8'hff, 12'd9, 12'd9, 12'd9, 12'd9, 12'd9);
    wait_drained();
    clock_us = 48'h0310_0020;
  endtask

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++)
      send_tick(next_time(), 8'($urandom), rand_sample(), rand_sample(), rand_sample(),
                rand_sample(), rand_sample());
  endtask

  task automatic random_config();
    write_reg(REG_FILTER_SHIFT, $urandom_range(15));
    write_reg(REG_DEAD_ZONE, $urandom_range(3) == 0 ? $urandom_range(127) : $urandom_range(20));
    write_reg(REG_CENTER_LX, $urandom_range(4095));
    write_reg(REG_CENTER_LY, $urandom_range(1900, 2200));
    write_reg(REG_CENTER_RX, $urandom_range(4095));
    write_reg(REG_CENTER_RY, $urandom_range(1900, 2200));
    write_reg(REG_DEBOUNCE_TIME, $urandom_range(3) == 0 ? $urandom : $urandom_range(30000));
    write_reg(REG_LONG_TIME, $urandom_range(3) == 0 ? $urandom : $urandom_range(200000));
  endtask

  initial begin
    rst_n = 0;
    in_valid = 0;
    in_now_us = '0;
    in_button_levels = '1;
    {in_sample_left_x, in_sample_left_y, in_sample_right_x} = '0;
    {in_sample_right_y, in_sample_battery} = '0;
    cfg_we = 0;
    cfg_index = REG_FILTER_SHIFT;
    cfg_wdata = '0;
    p_shift = 2;
    p_dead_zone = 5;
    for (int i = 0; i < AXES; i++) p_center[i] = 2048;
    p_debounce = 40000;
    p_long = 800000;
    p_sampled = '1;
    p_stable = '1;
    for (int i = 0; i < 8; i++) begin
      p_change_t[i] = '0;
      p_press_t[i] = '0;
    end
    for (int i = 0; i < CHANNELS; i++) p_filtered[i] = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_reset_defaults();
    test_config_extremes();
    for (int ph = 0; ph < 6; ph++) begin
      random_config();
      random_phase(140);
      wait_drained();
    end
    idling_on = 0;
    random_phase(150);
    wait_drained();
    $display("covered %0d ticks, %0d checked, across reset defaults, register extremes",
             ticks_sent, ticks_checked);
    $display("and random debounce, filter and axis scaling settings");
    if (errors == 0) $display("tb_gamepad_input_conditioner_unit: PASS");
    else $display("tb_gamepad_input_conditioner_unit: FAIL");
    $finish;
  end
endmodule
